// File: rtl/bpf_pkg.sv
// Shared widths, constants and register codes of the boid pair force block.
package bpf_pkg;

  localparam int POS_FRAC_BITS = 14;
  localparam int SCALE_SHIFT   = 2 * POS_FRAC_BITS - 16;
  localparam int ONE_POS       = 1 << POS_FRAC_BITS;

  localparam int IN_W      = 16;
  localparam int IN_TD_W   = 4 * IN_W;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COH_RADIUS  = 3'd0,
    REG_SEP_RADIUS  = 3'd1,
    REG_COH_GAIN    = 3'd2,
    REG_SEP_GAIN    = 3'd3,
    REG_WALL_MARGIN = 3'd4,
    REG_WALL_GAIN   = 3'd5
  } cfg_reg_t;

  localparam logic [CFG_W-1:0] COH_RADIUS_RST  = 16'd8192;
  localparam logic [CFG_W-1:0] SEP_RADIUS_RST  = 16'd1638;
  localparam logic [CFG_W-1:0] COH_GAIN_RST    = 16'd256;
  localparam logic [CFG_W-1:0] SEP_GAIN_RST    = 16'd256;
  localparam logic [CFG_W-1:0] WALL_MARGIN_RST = 16'd1638;
  localparam logic [CFG_W-1:0] WALL_GAIN_RST   = 16'd256;

  localparam int V_W        = IN_W + 1;    // neighbour vector component
  localparam int MAG_W      = IN_W;        // |v|
  localparam int SQ_W       = 2 * MAG_W;   // v^2
  localparam int D2_W       = SQ_W + 1;    // squared length
  localparam int D_W        = (D2_W + 1) / 2;
  localparam int WT_W       = 17;          // margin minus wall distance
  localparam int WTT_W      = 2 * WT_W;
  localparam int WPROD_W    = WTT_W + CFG_W;
  localparam int WMAG_W     = 37;
  localparam int WALL_W     = WMAG_W + 1;
  localparam int CP_W       = CFG_W + MAG_W;
  localparam int CPROD_W    = CP_W + CFG_W;
  localparam int COH_MAG_W  = CPROD_W - SCALE_SHIFT;
  localparam int COH_W      = COH_MAG_W + 1;
  localparam int SEPA_W     = CPROD_W;
  localparam int SEP_SHIFT  = 16;
  localparam int SEP_NUM_W  = SEPA_W + SEP_SHIFT;
  localparam int SEP_Q_W    = 51;
  localparam int SEP_W      = SEP_Q_W + 1;
  localparam int SUM_W      = 53;

  localparam logic [SEP_Q_W-1:0] SEP_CLAMP = {1'b1, {(SEP_Q_W-1){1'b0}}};

  localparam int SQRT_LAT = D_W;
  localparam int DIV_LAT  = SEP_Q_W + 1;
  localparam int PIPE_LAT = 9 + SQRT_LAT + DIV_LAT;
  localparam int QDEPTH   = 1 << $clog2(PIPE_LAT + 4);
  localparam int OCC_W    = $clog2(QDEPTH) + 1;

endpackage

// File: rtl/bpf_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module bpf_isqrt #(
  parameter int IN_W = 33,
  localparam int OUT_W = (IN_W + 1) / 2
) (
  input  logic             clk,
  input  logic [IN_W-1:0]  rad,
  output logic [OUT_W-1:0] root
);

  localparam int PAD_W = 2 * OUT_W;
  localparam int RW    = OUT_W + 1;

  logic [PAD_W-1:0] rad_r    [OUT_W];
  logic [RW-1:0]    rem_r    [OUT_W];
  logic [OUT_W-1:0] root_r   [OUT_W];
  logic [PAD_W-1:0] rad_nxt  [OUT_W];
  logic [RW-1:0]    rem_nxt  [OUT_W];
  logic [OUT_W-1:0] root_nxt [OUT_W];

  always_comb begin
    logic [PAD_W-1:0] s_rad;
    logic [RW-1:0]    s_rem;
    logic [OUT_W-1:0] s_root;
    logic [RW+1:0]    cur;
    logic [RW+1:0]    trial;
    for (int k = 0; k < OUT_W; k++) begin
      s_rad  = (k == 0) ? PAD_W'(rad) : rad_r[k-1];
      s_rem  = (k == 0) ? '0 : rem_r[k-1];
      s_root = (k == 0) ? '0 : root_r[k-1];
      cur    = {s_rem, s_rad[PAD_W-1 -: 2]};
      trial  = (RW+2)'({s_root, 2'b01});
      if (cur >= trial) begin
        rem_nxt[k]  = RW'(cur - trial);
        root_nxt[k] = {s_root[OUT_W-2:0], 1'b1};
      end else begin
        rem_nxt[k]  = RW'(cur);
        root_nxt[k] = {s_root[OUT_W-2:0], 1'b0};
      end
      rad_nxt[k] = s_rad << 2;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < OUT_W; k++) begin
      rad_r[k]  <= rad_nxt[k];
      rem_r[k]  <= rem_nxt[k];
      root_r[k] <= root_nxt[k];
    end
  end

  assign root = root_r[OUT_W-1];

endmodule

// File: rtl/bpf_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow flag.
module bpf_div #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 33,
  parameter int Q_W   = 51
) (
  input  logic             clk,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quo,
  output logic             ovf
);

  // the numerator bits above the quotient must fit the remainder width
  localparam int HI_W = NUM_W - Q_W;

  logic [DEN_W-1:0] rem_r   [Q_W+1];
  logic [Q_W-1:0]   q_r     [Q_W+1];
  logic [Q_W-1:0]   low_r   [Q_W+1];
  logic [DEN_W-1:0] den_r   [Q_W+1];
  logic             ovf_r   [Q_W+1];
  logic [DEN_W-1:0] rem_nxt [Q_W+1];
  logic [Q_W-1:0]   q_nxt   [Q_W+1];
  logic [Q_W-1:0]   low_nxt [Q_W+1];
  logic [DEN_W-1:0] den_nxt [Q_W+1];
  logic             ovf_nxt [Q_W+1];

  always_comb begin
    logic [HI_W-1:0]  hi;
    logic [DEN_W:0]   cur;
    logic             ge;
    for (int k = 0; k <= Q_W; k++) begin
      hi  = num[NUM_W-1:Q_W];
      cur = '0;
      ge  = 1'b0;
      if (k == 0) begin
        ovf_nxt[k] = DEN_W'(hi) >= den;
        rem_nxt[k] = DEN_W'(hi);
        q_nxt[k]   = '0;
        low_nxt[k] = num[Q_W-1:0];
        den_nxt[k] = den;
      end else begin
        cur        = {rem_r[k-1], low_r[k-1][Q_W-1]};
        ge         = cur >= (DEN_W+1)'(den_r[k-1]);
        rem_nxt[k] = ge ? DEN_W'(cur - (DEN_W+1)'(den_r[k-1])) : DEN_W'(cur);
        q_nxt[k]   = {q_r[k-1][Q_W-2:0], ge};
        low_nxt[k] = low_r[k-1] << 1;
        den_nxt[k] = den_r[k-1];
        ovf_nxt[k] = ovf_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k <= Q_W; k++) begin
      rem_r[k] <= rem_nxt[k];
      q_r[k]   <= q_nxt[k];
      low_r[k] <= low_nxt[k];
      den_r[k] <= den_nxt[k];
      ovf_r[k] <= ovf_nxt[k];
    end
  end

  assign quo = q_r[Q_W];
  assign ovf = ovf_r[Q_W];

endmodule

// File: rtl/bpf_outq.sv
// Result queue: memory with registered read, a read stage and an output register.
module bpf_outq #(
  parameter int DATA_W = 65,
  parameter int DEPTH  = 128
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [DATA_W-1:0] wr_data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DATA_W-1:0] out_data
);

  localparam int AW = $clog2(DEPTH);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [AW:0]       cnt_r, cnt_nxt;
  logic [DATA_W-1:0] rd_data_r, out_data_r;
  logic              rd_vld_r, rd_vld_nxt, out_vld_r, out_vld_nxt;
  logic              hand, issue;

  assign hand  = rd_vld_r && (!out_vld_r || out_ready);
  assign issue = (cnt_r != '0) && (!rd_vld_r || hand);

  always_comb begin
    cnt_nxt     = cnt_r + (AW+1)'(wr_en) - (AW+1)'(issue);
    rd_vld_nxt  = issue ? 1'b1 : (hand ? 1'b0 : rd_vld_r);
    out_vld_nxt = hand ? 1'b1 : (out_ready ? 1'b0 : out_vld_r);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr_r] <= wr_data;
    end
    if (issue) begin
      rd_data_r <= mem[rd_ptr_r];
    end
    if (hand) begin
      out_data_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      cnt_r     <= '0;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (issue) rd_ptr_r <= rd_ptr_r + 1'b1;
      cnt_r     <= cnt_nxt;
      rd_vld_r  <= rd_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/boid_pair_force.sv
// Top level of the boid pair force pipeline.
//
//   channel  | direction | handshake          | payload
//   in_      | slave     | in_tvalid/tready   | tdata: self_x, self_y, other_x, other_y
//   out_     | master    | out_tvalid/tready  | tdata: force_x, force_y; tuser: saturated
//   cfg_     | slave     | cfg_valid/ready    | cfg_index, cfg_data (16-bit register value)
//
// One pair is accepted per cycle while credits remain. On the way from input
// transaction to the output queue, 17 square-root stages and 52 divider stages
// dominate. The queue's read stage and output register precede out_tvalid.
// The pipeline itself never stalls; a credit counter of 128 transactions in flight
// gates in_tready, so a stalled output only stops input once the queue would fill.
// rst_n is synchronous; it clears valid bits and credits and loads config defaults.
// cfg_ready is always high; write configuration only while no pair is in flight.
module boid_pair_force #(
  parameter int FORCE_WIDTH = 32,
  localparam int OUT_TD_W = ((2 * FORCE_WIDTH + 7) / 8) * 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [bpf_pkg::IN_TD_W-1:0]   in_tdata,   // self_x, self_y, other_x, other_y
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [OUT_TD_W-1:0]           out_tdata,  // force_x, force_y, zero pad
  output logic                          out_tuser,  // saturated
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bpf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpf_pkg::CFG_W-1:0]     cfg_data
);

  import bpf_pkg::*;

  typedef struct packed {
    logic [MAG_W-1:0]         ax;
    logic [MAG_W-1:0]         ay;
    logic                     nx;
    logic                     ny;
    logic signed [WALL_W-1:0] wall_x;
    logic signed [WALL_W-1:0] wall_y;
    logic [D2_W-1:0]          d2;
  } side_t;

  typedef struct packed {
    logic signed [COH_W-1:0]  coh_x;
    logic signed [COH_W-1:0]  coh_y;
    logic signed [WALL_W-1:0] wall_x;
    logic signed [WALL_W-1:0] wall_y;
    logic                     nx;
    logic                     ny;
    logic                     sep_en;
  } tail_t;

  localparam logic signed [17:0] ONE_S = 18'(ONE_POS);

  // Margin minus wall distance, zero when the boid is outside the margin.
  function automatic logic [WT_W-1:0] wall_gap(logic signed [IN_W-1:0] p,
                                               logic [CFG_W-1:0] m);
    logic signed [17:0] wd;
    logic signed [17:0] diff;
    wd   = (p < 0) ? ONE_S + 18'(p) : ONE_S - 18'(p);
    diff = $signed({2'b00, m}) - wd;
    return (diff > 0) ? diff[WT_W-1:0] : '0;
  endfunction

  // Clip one axis to the force range; the top bit flags a clip.
  function automatic logic [FORCE_WIDTH:0] clip(logic signed [SUM_W-1:0] s);
    logic [SUM_W-FORCE_WIDTH:0] up;
    logic                       hit;
    up  = s[SUM_W-1:FORCE_WIDTH-1];
    hit = !((&up) || !(|up));
    if (!hit) return {1'b0, s[FORCE_WIDTH-1:0]};
    if (s[SUM_W-1]) return {1'b1, 1'b1, {(FORCE_WIDTH-1){1'b0}}};
    return {1'b1, 1'b0, {(FORCE_WIDTH-1){1'b1}}};
  endfunction

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0] coh_rad_r, sep_rad_r, coh_gain_r, sep_gain_r, wall_mrg_r, wall_gain_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coh_rad_r   <= COH_RADIUS_RST;
      sep_rad_r   <= SEP_RADIUS_RST;
      coh_gain_r  <= COH_GAIN_RST;
      sep_gain_r  <= SEP_GAIN_RST;
      wall_mrg_r  <= WALL_MARGIN_RST;
      wall_gain_r <= WALL_GAIN_RST;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_COH_RADIUS:  coh_rad_r   <= cfg_data;
        REG_SEP_RADIUS:  sep_rad_r   <= cfg_data;
        REG_COH_GAIN:    coh_gain_r  <= cfg_data;
        REG_SEP_GAIN:    sep_gain_r  <= cfg_data;
        REG_WALL_MARGIN: wall_mrg_r  <= cfg_data;
        REG_WALL_GAIN:   wall_gain_r <= cfg_data;
        default: ;  // drop writes to unknown registers
      endcase
    end
  end

  // ---------------------------------------------------------------- credits
  logic             in_acc, out_acc;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic [PIPE_LAT-1:0] vld_r;

  assign in_tready = occ_r < OCC_W'(QDEPTH);
  assign in_acc    = in_tvalid && in_tready;
  assign out_acc   = out_tvalid && out_tready;
  assign occ_nxt   = occ_r + OCC_W'(in_acc) - OCC_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
      vld_r <= '0;
    end else begin
      occ_r <= occ_nxt;
      vld_r <= {vld_r[PIPE_LAT-2:0], in_acc};  // valid travels with each stage
    end
  end

  // ---------------------------------------------------------------- front end
  logic signed [IN_W-1:0] sx, sy, ox, oy;
  assign sx = $signed(in_tdata[IN_W-1:0]);
  assign sy = $signed(in_tdata[2*IN_W-1:IN_W]);
  assign ox = $signed(in_tdata[3*IN_W-1:2*IN_W]);
  assign oy = $signed(in_tdata[4*IN_W-1:3*IN_W]);

  // stage 1: neighbour vector, wall gaps
  logic signed [V_W-1:0] vx1_r, vy1_r;
  logic [WT_W-1:0]       wtx1_r, wty1_r;
  logic                  wnx1_r, wny1_r;
  // stage 2: magnitudes, squared wall gaps
  logic [MAG_W-1:0]      ax2_r, ay2_r;
  logic                  nx2_r, ny2_r, wnx2_r, wny2_r;
  logic [WTT_W-1:0]      wttx2_r, wtty2_r;
  // stage 3: squares, wall terms
  logic [SQ_W-1:0]       sqx3_r, sqy3_r;
  logic [MAG_W-1:0]      ax3_r, ay3_r;
  logic                  nx3_r, ny3_r;
  logic signed [WALL_W-1:0] wallx3_r, wally3_r;
  // stage 4: squared length
  side_t                 side4_r;

  logic [WPROD_W-1:0]    wprod_x, wprod_y;
  logic [WMAG_W-1:0]     wmag_x, wmag_y;

  assign wprod_x = WPROD_W'(wttx2_r) * WPROD_W'(wall_gain_r);
  assign wprod_y = WPROD_W'(wtty2_r) * WPROD_W'(wall_gain_r);
  assign wmag_x  = wprod_x[SCALE_SHIFT +: WMAG_W];
  assign wmag_y  = wprod_y[SCALE_SHIFT +: WMAG_W];

  always_ff @(posedge clk) begin
    vx1_r  <= V_W'(ox) - V_W'(sx);
    vy1_r  <= V_W'(oy) - V_W'(sy);
    wtx1_r <= wall_gap(sx, wall_mrg_r);
    wty1_r <= wall_gap(sy, wall_mrg_r);
    wnx1_r <= sx < 0;
    wny1_r <= sy < 0;

    ax2_r   <= (vx1_r < 0) ? MAG_W'(-vx1_r) : MAG_W'(vx1_r);
    ay2_r   <= (vy1_r < 0) ? MAG_W'(-vy1_r) : MAG_W'(vy1_r);
    nx2_r   <= vx1_r < 0;
    ny2_r   <= vy1_r < 0;
    wnx2_r  <= wnx1_r;
    wny2_r  <= wny1_r;
    wttx2_r <= WTT_W'(wtx1_r) * WTT_W'(wtx1_r);
    wtty2_r <= WTT_W'(wty1_r) * WTT_W'(wty1_r);

    sqx3_r   <= SQ_W'(ax2_r) * SQ_W'(ax2_r);
    sqy3_r   <= SQ_W'(ay2_r) * SQ_W'(ay2_r);
    ax3_r    <= ax2_r;
    ay3_r    <= ay2_r;
    nx3_r    <= nx2_r;
    ny3_r    <= ny2_r;
    // the wall pushes toward the center
    wallx3_r <= wnx2_r ? $signed({1'b0, wmag_x}) : -$signed({1'b0, wmag_x});
    wally3_r <= wny2_r ? $signed({1'b0, wmag_y}) : -$signed({1'b0, wmag_y});

    side4_r.ax     <= ax3_r;
    side4_r.ay     <= ay3_r;
    side4_r.nx     <= nx3_r;
    side4_r.ny     <= ny3_r;
    side4_r.wall_x <= wallx3_r;
    side4_r.wall_y <= wally3_r;
    side4_r.d2     <= D2_W'(sqx3_r) + D2_W'(sqy3_r);
  end

  // ---------------------------------------------------------------- distance
  logic [D_W-1:0] root;
  side_t          side_q [SQRT_LAT];
  side_t          side_d;

  bpf_isqrt #(.IN_W(D2_W)) u_isqrt (
    .clk  (clk),
    .rad  (side4_r.d2),
    .root (root)
  );

  // hold the side data beside the square root
  always_ff @(posedge clk) begin
    side_q[0] <= side4_r;
    for (int k = 1; k < SQRT_LAT; k++) begin
      side_q[k] <= side_q[k-1];
    end
  end
  assign side_d = side_q[SQRT_LAT-1];

  // ---------------------------------------------------------------- terms
  logic [CFG_W-1:0]  cdiff22_r, sdiff22_r;
  logic              sep_en22_r;
  side_t             s22_r;
  logic [CP_W-1:0]   cpx23_r, cpy23_r, spx23_r, spy23_r;
  logic              sep_en23_r;
  side_t             s23_r;
  tail_t             t24_r;
  logic [SEPA_W-1:0] sax24_r, say24_r;
  logic [D2_W-1:0]   d2_24_r;
  logic              coh_en, sep_en;
  logic [CPROD_W-1:0]   cprod_x, cprod_y;
  logic [COH_MAG_W-1:0] cmag_x, cmag_y;

  assign coh_en  = {1'b0, coh_rad_r} >= root;
  assign sep_en  = ({1'b0, sep_rad_r} >= root) && (side_d.d2 != '0);
  assign cprod_x = CPROD_W'(cpx23_r) * CPROD_W'(coh_gain_r);
  assign cprod_y = CPROD_W'(cpy23_r) * CPROD_W'(coh_gain_r);
  assign cmag_x  = cprod_x[SCALE_SHIFT +: COH_MAG_W];
  assign cmag_y  = cprod_y[SCALE_SHIFT +: COH_MAG_W];

  always_ff @(posedge clk) begin
    // radius minus distance; zero outside the radius kills the term
    cdiff22_r  <= coh_en ? coh_rad_r - root[CFG_W-1:0] : '0;
    sdiff22_r  <= sep_en ? sep_rad_r - root[CFG_W-1:0] : '0;
    sep_en22_r <= sep_en;
    s22_r      <= side_d;

    cpx23_r    <= CP_W'(cdiff22_r) * CP_W'(s22_r.ax);
    cpy23_r    <= CP_W'(cdiff22_r) * CP_W'(s22_r.ay);
    spx23_r    <= CP_W'(sdiff22_r) * CP_W'(s22_r.ax);
    spy23_r    <= CP_W'(sdiff22_r) * CP_W'(s22_r.ay);
    sep_en23_r <= sep_en22_r;
    s23_r      <= s22_r;

    t24_r.coh_x  <= s23_r.nx ? -$signed({1'b0, cmag_x}) : $signed({1'b0, cmag_x});
    t24_r.coh_y  <= s23_r.ny ? -$signed({1'b0, cmag_y}) : $signed({1'b0, cmag_y});
    t24_r.wall_x <= s23_r.wall_x;
    t24_r.wall_y <= s23_r.wall_y;
    t24_r.nx     <= s23_r.nx;
    t24_r.ny     <= s23_r.ny;
    t24_r.sep_en <= sep_en23_r;
    sax24_r      <= SEPA_W'(spx23_r) * SEPA_W'(sep_gain_r);
    say24_r      <= SEPA_W'(spy23_r) * SEPA_W'(sep_gain_r);
    d2_24_r      <= s23_r.d2;
  end

  // ---------------------------------------------------------------- separation divide
  logic [SEP_Q_W-1:0] qx, qy;
  logic               ovx, ovy;
  tail_t              tail_q [DIV_LAT];
  tail_t              tail_d;

  bpf_div #(.NUM_W(SEP_NUM_W), .DEN_W(D2_W), .Q_W(SEP_Q_W)) u_div_x (
    .clk (clk),
    .num ({sax24_r, {SEP_SHIFT{1'b0}}}),
    .den (d2_24_r),
    .quo (qx),
    .ovf (ovx)
  );

  bpf_div #(.NUM_W(SEP_NUM_W), .DEN_W(D2_W), .Q_W(SEP_Q_W)) u_div_y (
    .clk (clk),
    .num ({say24_r, {SEP_SHIFT{1'b0}}}),
    .den (d2_24_r),
    .quo (qy),
    .ovf (ovy)
  );

  always_ff @(posedge clk) begin
    tail_q[0] <= t24_r;
    for (int k = 1; k < DIV_LAT; k++) begin
      tail_q[k] <= tail_q[k-1];
    end
  end
  assign tail_d = tail_q[DIV_LAT-1];

  // ---------------------------------------------------------------- sum and clip
  logic [SEP_Q_W-1:0]      smag_x, smag_y;
  logic signed [SEP_W-1:0] sepx77_r, sepy77_r;
  tail_t                   t77_r;
  logic signed [SUM_W-1:0] sumx78_r, sumy78_r;
  logic [FORCE_WIDTH:0]    clip_x, clip_y;
  logic [2*FORCE_WIDTH:0]  q_in, q_out;

  // clamp a huge separation push; it always saturates downstream
  assign smag_x = (ovx || (qx > SEP_CLAMP)) ? SEP_CLAMP : qx;
  assign smag_y = (ovy || (qy > SEP_CLAMP)) ? SEP_CLAMP : qy;

  always_ff @(posedge clk) begin
    sepx77_r <= !tail_d.sep_en ? '0 :
                (tail_d.nx ? $signed({1'b0, smag_x}) : -$signed({1'b0, smag_x}));
    sepy77_r <= !tail_d.sep_en ? '0 :
                (tail_d.ny ? $signed({1'b0, smag_y}) : -$signed({1'b0, smag_y}));
    t77_r    <= tail_d;

    sumx78_r <= SUM_W'(t77_r.wall_x) + SUM_W'(t77_r.coh_x) + SUM_W'(sepx77_r);
    sumy78_r <= SUM_W'(t77_r.wall_y) + SUM_W'(t77_r.coh_y) + SUM_W'(sepy77_r);
  end

  assign clip_x = clip(sumx78_r);
  assign clip_y = clip(sumy78_r);
  assign q_in   = {clip_x[FORCE_WIDTH] | clip_y[FORCE_WIDTH],
                   clip_y[FORCE_WIDTH-1:0], clip_x[FORCE_WIDTH-1:0]};

  bpf_outq #(.DATA_W(2 * FORCE_WIDTH + 1), .DEPTH(QDEPTH)) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (vld_r[PIPE_LAT-1]),
    .wr_data   (q_in),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (q_out)
  );

  assign out_tdata = OUT_TD_W'(q_out[2*FORCE_WIDTH-1:0]);
  assign out_tuser = q_out[2*FORCE_WIDTH];

`ifndef ASSERT_OFF
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(QDEPTH))
    else $error("credit count above queue depth");

  a_out_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> occ_r != '0)
    else $error("result presented with no transaction in flight");

  a_pipe_has_credit: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[PIPE_LAT-1] |-> occ_r != '0)
    else $error("pipeline result with no transaction in flight");

  a_no_accept_full: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == OCC_W'(QDEPTH)) |=> occ_r <= $past(occ_r))
    else $error("credit count grew while full");
`endif

endmodule
